### design/multi_stop_color_gradient_assert.svh
`ifndef MULTI_STOP_COLOR_GRADIENT_ASSERT_SVH
`define MULTI_STOP_COLOR_GRADIENT_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define MSCG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define MSCG_ASSERT_NEXT(lbl, cond, expect_next, msg) \
    `MSCG_ASSERT(lbl, (cond) |=> (expect_next), msg)

`endif

### design/mscg_pkg.sv
package mscg_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int STOP_W     = 17;
    localparam int COLOR_W    = 24;
    localparam int MAG_W      = 32;
    localparam int SCALED_W   = 39;
    localparam int NUM_W      = 29;
    localparam int TWICE_W    = 32;
    localparam int REM_W      = 27;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FEW  = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    localparam logic CFG_LOOP_MODE     = 1'b0;
    localparam logic CFG_REPEAT_FACTOR = 1'b1;

    typedef struct packed {
        logic accept;
        logic scale;
        logic fold;
        logic search;
        logic rd_before;
        logic rd_after;
        logic cap_start;
        logic cap_end;
        logic mix;
        logic prep;
        logic div;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic few;
        logic search_done;
        logic zero_range;
        logic div_last;
    } t_sts;

endpackage

### design/mscg_ram.sv
module mscg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/mscg_datapath.sv
module mscg_datapath
    import mscg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_position,
    input  logic [16:0]        i_entry_stop,
    input  logic [7:0]         i_entry_red,
    input  logic [7:0]         i_entry_green,
    input  logic [7:0]         i_entry_blue,
    output logic               o_valid,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [1:0]         o_status
);

    logic                     r_loop_mode;
    logic signed [15:0]       r_repeat;
    logic [IDX_W-1:0]         r_count;
    logic [MAG_W-1:0]         r_mag;
    logic [SCALED_W-1:0]      r_scaled;
    logic [STOP_W-1:0]        r_read;
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         r_pidx;
    logic                     r_pv;
    logic [IDX_W-1:0]         r_before;
    logic [STOP_W-1:0]        r_s0;
    logic [STOP_W-1:0]        r_s1;
    logic [COLOR_W-1:0]       r_c0;
    logic [COLOR_W-1:0]       r_c1;
    logic signed [STOP_W:0]   r_range;
    logic signed [NUM_W-1:0]  r_num [3];
    logic [REM_W-1:0]         r_rem [3];
    logic                     r_neg [3];
    logic                     r_sat [3];
    logic [7:0]               r_q [3];
    logic [STOP_W-1:0]        r_den;
    logic [2:0]               r_bit;
    logic                     r_valid;
    logic [7:0]               r_red;
    logic [7:0]               r_green;
    logic [7:0]               r_blue;
    logic [1:0]               r_status;

    logic                     table_we;
    logic [IDX_W-1:0]         rd_addr;
    logic [STOP_W-1:0]        stop_q;
    logic [COLOR_W-1:0]       color_q;
    logic [IDX_W-1:0]         last_idx;
    logic [MAG_W-1:0]         abs_pos;
    logic [SCALED_W-1:0]      n_scaled;
    logic [STOP_W-1:0]        n_read;
    logic signed [STOP_W:0]   range_c;
    logic signed [STOP_W:0]   into_c;
    logic [7:0]               chan [3];

    function automatic logic signed [NUM_W-1:0] mix_num(
        input logic [7:0]             a,
        input logic [7:0]             b,
        input logic signed [STOP_W:0] rng,
        input logic signed [STOP_W:0] into
    );
        logic signed [NUM_W-1:0] ea;
        logic signed [NUM_W-1:0] ediff;
        ea    = NUM_W'(signed'({1'b0, a}));
        ediff = NUM_W'(signed'({1'b0, b})) - ea;
        return ea * NUM_W'(rng) + ediff * NUM_W'(into);
    endfunction

    function automatic logic [REM_W-2:0] den_ext(input logic [STOP_W-1:0] d);
        return (REM_W-1)'(d);
    endfunction

    assign table_we = i_cmd.accept && (i_kind == KIND_APPEND)
                      && ({1'b0, r_count} + 1'b1 < (IDX_W+1)'(TABLE_SIZE));
    assign last_idx = r_count - IDX_W'(2);
    assign abs_pos  = i_position[31] ? (~i_position + 32'd1) : i_position;

    always_comb begin
        rd_addr = r_idx;
        if (i_cmd.rd_before) begin
            rd_addr = r_before;
        end else if (i_cmd.rd_after) begin
            rd_addr = r_before + IDX_W'(1);
        end
    end

    mscg_ram #(.WIDTH(STOP_W), .DEPTH(TABLE_SIZE)) u_stop_ram (
        .i_clk   (i_clk),
        .i_we    (table_we),
        .i_waddr (r_count),
        .i_wdata (i_entry_stop),
        .i_raddr (rd_addr),
        .o_rdata (stop_q)
    );

    mscg_ram #(.WIDTH(COLOR_W), .DEPTH(TABLE_SIZE)) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (table_we),
        .i_waddr (r_count),
        .i_wdata ({i_entry_red, i_entry_green, i_entry_blue}),
        .i_raddr (rd_addr),
        .o_rdata (color_q)
    );

    always_comb begin
        logic [MAG_W+15-1:0] prod;
        prod = r_mag * r_repeat[14:0];
        if (r_repeat > 16'sd0) begin
            n_scaled = prod[MAG_W+15-1:8];
        end else begin
            n_scaled = SCALED_W'(r_mag);
        end
    end

    // Above 1.0 only the fraction survives; mirror mode flips odd periods.
    always_comb begin
        if (r_scaled > SCALED_W'(65536)) begin
            if (r_loop_mode && r_scaled[16]) begin
                n_read = 17'd65536 - {1'b0, r_scaled[15:0]};
            end else begin
                n_read = {1'b0, r_scaled[15:0]};
            end
        end else begin
            n_read = r_scaled[STOP_W-1:0];
        end
    end

    assign range_c = signed'({1'b0, r_s1}) - signed'({1'b0, r_s0});
    assign into_c  = signed'({1'b0, r_read}) - signed'({1'b0, r_s0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_mode <= 1'b0;
            r_repeat    <= 16'sd256;
            r_count     <= '0;
            r_valid     <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOOP_MODE:     r_loop_mode <= i_cfg_wdata[0];
                    CFG_REPEAT_FACTOR: r_repeat    <= i_cfg_wdata;
                    default:           r_loop_mode <= r_loop_mode;
                endcase
            end
            if (i_cmd.accept && i_kind == KIND_CLEAR) begin
                r_count <= '0;
            end else if (table_we) begin
                r_count <= r_count + IDX_W'(1);
            end
            if (i_cmd.fold) begin
                r_pv <= 1'b0;
            end else if (i_cmd.search) begin
                r_pv <= 1'b1;
            end
            r_valid <= i_cmd.load_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mag <= abs_pos;
        end
        if (i_cmd.scale) begin
            r_scaled <= n_scaled;
        end
        if (i_cmd.fold) begin
            r_read   <= n_read;
            r_idx    <= '0;
            r_before <= last_idx;
        end
        if (i_cmd.search) begin
            r_idx  <= r_idx + IDX_W'(1);
            r_pidx <= r_idx;
            if (r_pv && r_read >= stop_q) begin
                r_before <= r_pidx;
            end
        end
        if (i_cmd.cap_start) begin
            r_s0 <= stop_q;
            r_c0 <= color_q;
        end
        if (i_cmd.cap_end) begin
            r_s1 <= stop_q;
            r_c1 <= color_q;
        end
        if (i_cmd.mix) begin
            r_range <= range_c;
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= mix_num(r_c0[16-8*c +: 8], r_c1[16-8*c +: 8], range_c, into_c);
            end
        end
        if (i_cmd.prep) begin
            logic [STOP_W-1:0]        den;
            logic signed [TWICE_W-1:0] twice;
            den   = r_range[STOP_W] ? STOP_W'(-r_range) : r_range[STOP_W-1:0];
            r_den <= den;
            r_bit <= 3'd7;
            for (int c = 0; c < 3; c++) begin
                twice = r_range[STOP_W] ? -(TWICE_W'(r_num[c]) <<< 1)
                                        : (TWICE_W'(r_num[c]) <<< 1);
                twice = twice + TWICE_W'(signed'({1'b0, den}));
                r_neg[c] <= twice[TWICE_W-1];
                r_sat[c] <= twice >= TWICE_W'(signed'({1'b0, den, 9'd0}));
                r_rem[c] <= twice[REM_W-1:0];
                r_q[c]   <= 8'd0;
            end
        end
        if (i_cmd.div) begin
            logic [REM_W-1:0] trial;
            trial = REM_W'({den_ext(r_den), 1'b0}) << r_bit;
            r_bit <= r_bit - 3'd1;
            for (int c = 0; c < 3; c++) begin
                if (r_rem[c] >= trial) begin
                    r_rem[c]       <= r_rem[c] - trial;
                    r_q[c][r_bit]  <= 1'b1;
                end
            end
        end
        if (i_cmd.load_out) begin
            if (r_count < IDX_W'(2)) begin
                r_red    <= 8'd0;
                r_green  <= 8'd0;
                r_blue   <= 8'd0;
                r_status <= STATUS_FEW;
            end else if (r_range == '0) begin
                r_red    <= r_c0[23:16];
                r_green  <= r_c0[15:8];
                r_blue   <= r_c0[7:0];
                r_status <= STATUS_ZERO;
            end else begin
                r_red    <= chan[0];
                r_green  <= chan[1];
                r_blue   <= chan[2];
                r_status <= STATUS_OK;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_neg[c]) begin
                chan[c] = 8'd0;
            end else if (r_sat[c]) begin
                chan[c] = 8'd255;
            end else begin
                chan[c] = r_q[c];
            end
        end
    end

    assign o_sts.few         = r_count < IDX_W'(2);
    assign o_sts.search_done = r_pv && (r_pidx == last_idx);
    assign o_sts.zero_range  = r_range == '0;
    assign o_sts.div_last    = r_bit == 3'd0;

    assign o_valid  = r_valid;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
    assign o_status = r_status;

endmodule

### design/mscg_ctrl.sv
module mscg_ctrl
    import mscg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_kind,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SCALE  = 11'b00000000010,
        S_FOLD   = 11'b00000000100,
        S_SEARCH = 11'b00000001000,
        S_RD0    = 11'b00000010000,
        S_RD1    = 11'b00000100000,
        S_RD2    = 11'b00001000000,
        S_MIX    = 11'b00010000000,
        S_PREP   = 11'b00100000000,
        S_DIV    = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind == KIND_LOOKUP) begin
                        n_state = i_sts.few ? S_OUT : S_SCALE;
                    end
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = S_SEARCH;
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.search_done) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                o_cmd.rd_before = 1'b1;
                n_state         = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_after  = 1'b1;
                o_cmd.cap_start = 1'b1;
                n_state         = S_RD2;
            end
            S_RD2: begin
                o_cmd.cap_end = 1'b1;
                n_state       = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_sts.zero_range ? S_OUT : S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.load_out = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;

endmodule

### design/multi_stop_color_gradient.sv
// Gradient lookup with a table of up to fifteen stops. Append and clear commands
// finish in the cycle they are accepted. A lookup with fewer than two entries
// goes straight to its result word. Any other lookup compares one stop per cycle
// through the stop memory read port; unless its segment has zero width, three
// channels are then divided one quotient bit per cycle. busy stays high until
// the word is shown. Each result word is shown for one cycle on o_valid and
// cannot be stalled.
module multi_stop_color_gradient
    import mscg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_position,
    input  logic [16:0]        i_entry_stop,
    input  logic [7:0]         i_entry_red,
    input  logic [7:0]         i_entry_green,
    input  logic [7:0]         i_entry_blue,
    output logic               o_valid,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [1:0]         o_status
);

    t_cmd cmd;
    t_sts sts;

    mscg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    mscg_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_entry_stop  (i_entry_stop),
        .i_entry_red   (i_entry_red),
        .i_entry_green (i_entry_green),
        .i_entry_blue  (i_entry_blue),
        .o_valid       (o_valid),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_status      (o_status)
    );

endmodule

### design/mscg_checker.sv
`include "multi_stop_color_gradient_assert.svh"

module mscg_checker
    import mscg_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_kind,
    input logic               o_valid,
    input logic [1:0]         o_status
);

    // A result word never repeats in the following cycle.
    `MSCG_ASSERT_NEXT(a_single_word, o_valid, !o_valid, "result strobe held two cycles")
    // Table commands complete at once.
    `MSCG_ASSERT_NEXT(a_cmd_quick, start && !busy && i_kind != KIND_LOOKUP, !busy,
        "table command left the block busy")
    // A lookup always occupies the block.
    `MSCG_ASSERT_NEXT(a_lookup_busy, start && !busy && i_kind == KIND_LOOKUP, busy,
        "lookup did not start")
    `MSCG_ASSERT(a_status_code, o_valid |-> o_status != 2'd3, "undefined status code")

endmodule

bind multi_stop_color_gradient mscg_checker u_mscg_checker (.*);

### tb/multi_stop_color_gradient_test.sv
`timescale 1ns / 100ps

module multi_stop_color_gradient_test;
    import mscg_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 48;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] status;
    } t_color;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [15:0]        i_cfg_wdata;
    logic [1:0]         i_kind;
    logic signed [31:0] i_position;
    logic [16:0]        i_entry_stop;
    logic [7:0]         i_entry_red;
    logic [7:0]         i_entry_green;
    logic [7:0]         i_entry_blue;
    logic               o_valid;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;
    logic [1:0]         o_status;

    // Shadow copy of the gradient table and registers.
    logic [16:0]        shadow_stop [TABLE_SIZE];
    logic [23:0]        shadow_color [TABLE_SIZE];
    int                 shadow_count;
    logic               shadow_mirror;
    logic signed [15:0] shadow_repeat;

    t_color expected_colors[$];
    int     error_count;
    int     lookups_sent;
    int     colors_checked;
    bit     idle_gaps_on;

    multi_stop_color_gradient u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_entry_stop (i_entry_stop),
        .i_entry_red  (i_entry_red),
        .i_entry_green(i_entry_green),
        .i_entry_blue (i_entry_blue),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_status     (o_status)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [7:0] blend_channel(longint a, longint b, longint into,
                                                 longint range);
        longint num;
        longint den;
        longint twice;
        longint q;
        num = a * range + (b - a) * into;
        den = range;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        twice = 2 * num + den;
        if (twice < 0) return 8'd0;
        q = twice / (2 * den);
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    function automatic t_color color_for_position(logic [31:0] raw);
        t_color     c;
        logic [31:0] absval;
        logic [63:0] mag;
        logic [63:0] readpos;
        logic [15:0] frac;
        int          lo;
        int          hi;
        longint      range;
        longint      into;
        logic [23:0] ca;
        logic [23:0] cb;
        if (shadow_count < 2) begin
            c = '{8'd0, 8'd0, 8'd0, STATUS_FEW};
            return c;
        end
        absval = raw[31] ? (~raw + 32'd1) : raw;
        mag = 64'(absval);
        if (raw == 32'h8000_0000) mag = 64'h8000_0000;
        if (shadow_repeat > 0) mag = (mag * 64'(shadow_repeat)) >> 8;
        if (mag > 64'd65536) begin
            frac = mag[15:0];
            readpos = (shadow_mirror && mag[16]) ? 64'd65536 - frac : 64'(frac);
        end else begin
            readpos = mag;
        end
        lo = 0;
        hi = shadow_count;
        for (int i = 0; i + 1 < shadow_count; i++) begin
            if (readpos >= 64'(shadow_stop[i])) begin
                lo = i;
                hi = i + 1;
            end
        end
        if (hi >= shadow_count) begin
            hi = shadow_count - 1;
            lo = hi - 1;
        end
        range = longint'(shadow_stop[hi]) - longint'(shadow_stop[lo]);
        into = longint'(readpos) - longint'(shadow_stop[lo]);
        ca = shadow_color[lo];
        cb = shadow_color[hi];
        if (range == 0) begin
            c = '{ca[23:16], ca[15:8], ca[7:0], STATUS_ZERO};
            return c;
        end
        c.red    = blend_channel(ca[23:16], cb[23:16], into, range);
        c.green  = blend_channel(ca[15:8], cb[15:8], into, range);
        c.blue   = blend_channel(ca[7:0], cb[7:0], into, range);
        c.status = STATUS_OK;
        return c;
    endfunction

    task automatic idle(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Holds start high until the word is taken; start is lowered only by idle() and drain().
    task automatic send_word(logic [1:0] kind, logic [31:0] pos, logic [16:0] stop,
                             logic [23:0] rgb);
        i_kind        <= kind;
        i_position    <= pos;
        i_entry_stop  <= stop;
        i_entry_red   <= rgb[23:16];
        i_entry_green <= rgb[15:8];
        i_entry_blue  <= rgb[7:0];
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        case (kind)
            KIND_LOOKUP: begin
                expected_colors.push_back(color_for_position(pos));
                lookups_sent++;
            end
            KIND_APPEND: begin
                if (shadow_count + 1 < TABLE_SIZE) begin
                    shadow_stop[shadow_count]  = stop;
                    shadow_color[shadow_count] = rgb;
                    shadow_count++;
                end
            end
            KIND_CLEAR: shadow_count = 0;
            default: ;
        endcase
        if (idle_gaps_on && $urandom_range(0, 3) == 0) idle($urandom_range(1, 10));
    endtask

    task automatic lookup(logic [31:0] pos);
        send_word(KIND_LOOKUP, pos, 17'($urandom), 24'($urandom));
    endtask

    task automatic append(logic [16:0] stop, logic [23:0] rgb);
        send_word(KIND_APPEND, $urandom, stop, rgb);
    endtask

    task automatic clear_table();
        send_word(KIND_CLEAR, $urandom, 17'($urandom), 24'($urandom));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LOOP_MODE) shadow_mirror = data[0];
        else shadow_repeat = data;
    endtask

    task automatic test_short_table();
        lookup(32'h0001_0000);
        append(17'd0, 24'hFFFFFF);
        lookup(32'h0000_8000);
        append(17'd65536, 24'h000000);
        lookup(32'h0000_0000);
    endtask

    task automatic test_extremes();
        lookup(32'h0000_8000);
        lookup(32'h7FFF_FFFF);
        lookup(32'h8000_0000);
        lookup(32'hFFFF_FFFF);
        lookup(32'h0001_0000);
        lookup(32'h0001_0001);
        send_word(KIND_UNUSED, 32'h0000_4000, 17'd0, 24'h0);
        // Repeated stop makes a zero-width segment; a stop past 1.0 and a smaller one after it unsort the table.
        clear_table();
        append(17'd16384, 24'h00FF00);
        append(17'd16384, 24'hFF0000);
        append(17'h1FFFF, 24'h0000FF);
        append(17'd100, 24'hAA55AA);
        lookup(32'h0000_4000);
        lookup(32'h0000_5000);
        lookup(32'h0000_0010);
        lookup(32'hFFFF_C000);
    endtask

    task automatic test_table_full();
        clear_table();
        for (int i = 0; i < TABLE_SIZE + 1; i++)
            append(17'(i * 4096), 24'($urandom));
        lookup(32'h0000_F800);
        lookup(32'h0000_FFFF);
    endtask

    task automatic test_registers();
        write_reg(CFG_LOOP_MODE, 16'd1);
        lookup(32'h0001_4000);
        lookup(32'h0002_4000);
        write_reg(CFG_REPEAT_FACTOR, 16'h7FFF);
        lookup(32'h7FFF_FFFF);
        lookup(32'h8000_0000);
        write_reg(CFG_REPEAT_FACTOR, 16'h8000);
        lookup(32'h0003_8000);
        write_reg(CFG_REPEAT_FACTOR, 16'd0);
        lookup(32'h0000_1234);
        write_reg(CFG_LOOP_MODE, 16'd0);
        write_reg(CFG_REPEAT_FACTOR, 16'd256);
    endtask

    task automatic fill_random_table();
        int          n;
        logic [16:0] stop;
        clear_table();
        n = $urandom_range(2, 8);
        if ($urandom_range(0, 7) == 0) n = $urandom_range(0, TABLE_SIZE + 1);
        stop = 17'd0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) stop = 17'($urandom);
            else stop = (i == 0) ? 17'($urandom_range(0, 8192))
                                 : 17'(stop + $urandom_range(0, 131072 / n));
            append(stop, 24'($urandom));
        end
    endtask

    task automatic test_random(int phases);
        logic [31:0] pos;
        for (int p = 0; p < phases; p++) begin
            if (p % 4 == 0) begin
                write_reg(CFG_LOOP_MODE, 16'($urandom_range(0, 1)));
                write_reg(CFG_REPEAT_FACTOR, $urandom_range(0, 3) == 0 ? 16'($urandom)
                                             : 16'($urandom_range(64, 1024)));
            end
            if (p == phases / 2) drain();
            if (p >= phases - 3) idle_gaps_on = 1'b0;
            fill_random_table();
            repeat ($urandom_range(5, 12)) begin
                case ($urandom_range(0, 9))
                    0: pos = $urandom;
                    1: begin
                        send_word(2'($urandom), $urandom, 17'($urandom), 24'($urandom));
                        pos = $urandom;
                    end
                    default: pos = 32'($signed($urandom_range(0, 6 * 65536)) - 3 * 65536);
                endcase
                lookup(pos);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_color want;
        if (i_rst_n && o_valid) begin
            if (expected_colors.size() == 0) begin
                $error("unexpected result word red=%0d green=%0d blue=%0d status=%0d",
                       o_red, o_green, o_blue, o_status);
                error_count++;
            end else begin
                want = expected_colors.pop_front();
                colors_checked++;
                if (o_red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_red);
                    error_count++;
                end
                if (o_green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_green);
                    error_count++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_blue);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #4ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        error_count    = 0;
        lookups_sent   = 0;
        colors_checked = 0;
        idle_gaps_on   = 1'b1;
        shadow_count   = 0;
        shadow_mirror  = 1'b0;
        shadow_repeat  = 16'sd256;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = 1'b0;
        i_cfg_wdata    = '0;
        i_kind         = KIND_CLEAR;
        i_position     = '0;
        i_entry_stop   = '0;
        i_entry_red    = '0;
        i_entry_green  = '0;
        i_entry_blue   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_table();
        test_extremes();
        test_table_full();
        test_registers();
        test_random(24);
        drain();
        $display("Checked %0d of %0d lookups over table builds, overflow, both loop modes",
                 colors_checked, lookups_sent);
        $display("and repeat factors from negative through zero to the largest value.");
        if (error_count == 0 && expected_colors.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/mscg_pkg.sv
design/mscg_ram.sv
design/mscg_datapath.sv
design/mscg_ctrl.sv
design/multi_stop_color_gradient.sv
design/mscg_checker.sv
tb/multi_stop_color_gradient_test.sv
